FILE: hw/rtl/ale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Array list engine package
// Transaction types, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    MODE_APPEND    = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_REMOVE    = 3'd2,
    MODE_ERASE     = 3'd3,
    MODE_FIND      = 3'd4,
    MODE_OVERWRITE = 3'd5,
    MODE_REVERSE   = 3'd6,
    MODE_DUMP      = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_INS_PUT,
    ST_REV_RLO,
    ST_REV_RHI,
    ST_REV_WLO,
    ST_REV_WHI
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [6:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [5:0]         index;
    logic signed [31:0] element;
    logic [6:0]         count;
    logic               last;
  } rsp_t;

endpackage : ale_pkg
`default_nettype wire

FILE: hw/rtl/array_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Array list engine
// Ordered list of signed words with a fixed capacity, operated on one
// transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   in_item carries mode, position and value. Each result is shown on out_item
//   for one cycle with out_strobe high; the receiver cannot stall it. The last
//   result of a transaction has last set, and busy is already low in that
//   cycle, so the next transaction may be taken on the same edge.
//   All entries sit in a single-port-read, single-port-write memory, and one
//   read and one write per cycle set the timing:
//     append, remove, overwrite, and failed operations: result from decode.
//     insert before the end: entries from the last down to position move up
//     one place, then the value is written; erase before the last entry:
//     entries above position move down one place; otherwise decode finishes.
//     find: entries are read from index 0 up to the first match; dump: every
//     entry is read in turn and shown, one result per cycle.
//     reverse: each pair is read low then high, then written low then high.
//   Reset clears the count and the control state; stored entries are not
//   cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module array_list_engine_unit
  import ale_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire req_t in_item,
  output logic      out_strobe,
  output rsp_t      out_item
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  req_t                  req_r, req_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         hi_r, hi_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         pend_idx_r, pend_idx_nxt;
  logic [DATA_WIDTH-1:0] tmp_r, tmp_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  rsp_t                  out_item_r, out_item_nxt;

  logic [DATA_WIDTH-1:0] store_r [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  logic [DATA_WIDTH-1:0] val_dw;
  logic [6:0]            n7;
  logic [AW-1:0]         pos_a;
  logic                  rev_more;

  assign val_dw   = DATA_WIDTH'(req_r.value);
  assign n7       = 7'(count_r);
  assign pos_a    = req_r.position[AW-1:0];
  assign rev_more = ({1'b0, ptr_r} + (AW+1)'(2)) < {1'b0, hi_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= store_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ptr_r      <= ptr_nxt;
    hi_r       <= hi_nxt;
    rem_r      <= rem_nxt;
    pend_idx_r <= pend_idx_nxt;
    tmp_r      <= tmp_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    req_nxt        = req_r;
    ptr_nxt        = ptr_r;
    hi_nxt         = hi_r;
    rem_nxt        = rem_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    tmp_nxt        = tmp_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    mem_we         = 1'b0;
    mem_waddr      = pos_a;
    mem_wdata      = val_dw;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        out_item_nxt.status = STAT_OK;
        out_item_nxt.last   = 1'b1;
        out_strobe_nxt      = 1'b1;
        state_nxt           = ST_IDLE;
        unique case (req_r.mode)
          MODE_APPEND: begin
            if (count_r == CW'(CAPACITY)) begin
              out_item_nxt.status = STAT_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
            end
          end
          MODE_INSERT: begin
            if (req_r.position > n7) begin
              out_item_nxt.status = STAT_RANGE;
            end else if (count_r == CW'(CAPACITY)) begin
              out_item_nxt.status = STAT_FULL;
            end else if (req_r.position == n7) begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              out_strobe_nxt = 1'b0;
              ptr_nxt        = AW'(count_r - CW'(1));
              rem_nxt        = CW'(n7 - req_r.position);
              state_nxt      = ST_SCAN;
            end
          end
          MODE_REMOVE: begin
            if (count_r == '0) begin
              out_item_nxt.status = STAT_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          MODE_ERASE: begin
            if (count_r == '0) begin
              out_item_nxt.status = STAT_EMPTY;
            end else if (req_r.position >= n7) begin
              out_item_nxt.status = STAT_RANGE;
            end else if (req_r.position == n7 - 7'd1) begin
              count_nxt = count_r - CW'(1);
            end else begin
              out_strobe_nxt = 1'b0;
              ptr_nxt        = pos_a + AW'(1);
              rem_nxt        = CW'(n7 - req_r.position - 7'd1);
              state_nxt      = ST_SCAN;
            end
          end
          MODE_FIND, MODE_DUMP: begin
            if (count_r == '0) begin
              if (req_r.mode == MODE_DUMP) begin
                out_item_nxt.status = STAT_EMPTY;
              end
            end else begin
              out_strobe_nxt = 1'b0;
              ptr_nxt        = '0;
              rem_nxt        = count_r;
              state_nxt      = ST_SCAN;
            end
          end
          MODE_OVERWRITE: begin
            if (count_r == '0) begin
              out_item_nxt.status = STAT_EMPTY;
            end else if (req_r.position >= n7) begin
              out_item_nxt.status = STAT_RANGE;
            end else begin
              mem_we = 1'b1;
            end
          end
          MODE_REVERSE: begin
            if (count_r >= CW'(2)) begin
              out_strobe_nxt = 1'b0;
              ptr_nxt        = '0;
              hi_nxt         = AW'(count_r - CW'(1));
              state_nxt      = ST_REV_RLO;
            end
          end
        endcase
      end

      ST_SCAN: begin
        if (rem_r != '0) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = ptr_r;
          rem_nxt      = rem_r - CW'(1);
          ptr_nxt      = (req_r.mode == MODE_INSERT) ? ptr_r - AW'(1) : ptr_r + AW'(1);
        end
        out_item_nxt.status = STAT_OK;
        mem_wdata           = rdata_r;
        if (pend_r) begin
          priority case (req_r.mode)
            MODE_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_idx_r + AW'(1);
              if (rem_r == '0) begin
                state_nxt = ST_INS_PUT;
              end
            end
            MODE_ERASE: begin
              mem_we    = 1'b1;
              mem_waddr = pend_idx_r - AW'(1);
              if (rem_r == '0) begin
                count_nxt         = count_r - CW'(1);
                out_item_nxt.last = 1'b1;
                out_strobe_nxt    = 1'b1;
                state_nxt         = ST_IDLE;
              end
            end
            MODE_FIND: begin
              if (rdata_r == val_dw) begin
                out_item_nxt.found = 1'b1;
                out_item_nxt.index = 6'(pend_idx_r);
                out_item_nxt.last  = 1'b1;
                out_strobe_nxt     = 1'b1;
                pend_nxt           = 1'b0;
                state_nxt          = ST_IDLE;
              end else if (rem_r == '0) begin
                out_item_nxt.last = 1'b1;
                out_strobe_nxt    = 1'b1;
                state_nxt         = ST_IDLE;
              end
            end
            default: begin
              out_item_nxt.index   = 6'(pend_idx_r);
              out_item_nxt.element = 32'(signed'(rdata_r));
              out_item_nxt.last    = (rem_r == '0);
              out_strobe_nxt       = 1'b1;
              if (rem_r == '0) begin
                state_nxt = ST_IDLE;
              end
            end
          endcase
        end
      end

      ST_INS_PUT: begin
        mem_we              = 1'b1;
        count_nxt           = count_r + CW'(1);
        out_item_nxt.status = STAT_OK;
        out_item_nxt.last   = 1'b1;
        out_strobe_nxt      = 1'b1;
        state_nxt           = ST_IDLE;
      end

      ST_REV_RLO: begin
        mem_re    = 1'b1;
        state_nxt = ST_REV_RHI;
      end

      ST_REV_RHI: begin
        mem_re    = 1'b1;
        mem_raddr = hi_r;
        tmp_nxt   = rdata_r;
        state_nxt = ST_REV_WLO;
      end

      ST_REV_WLO: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = rdata_r;
        state_nxt = ST_REV_WHI;
      end

      ST_REV_WHI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = tmp_r;
        ptr_nxt   = ptr_r + AW'(1);
        hi_nxt    = hi_r - AW'(1);
        if (rev_more) begin
          state_nxt = ST_REV_RLO;
        end else begin
          out_item_nxt.status = STAT_OK;
          out_item_nxt.last   = 1'b1;
          out_strobe_nxt      = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_item_nxt.count = 7'(count_nxt);
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // The final result of a transaction arrives when the engine is free again.
  a_last_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |-> !busy)
    else $error("final result while busy");

  // Intermediate results only come from a dump in progress.
  a_mid_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |-> (busy && out_item.status == STAT_OK))
    else $error("intermediate result with bad status or while idle");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.found) |-> (out_item.status == STAT_OK && out_item.last))
    else $error("found flag on a failed or partial result");

  // The count only moves by one, and only when a result is issued.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> out_strobe)
    else $error("count changed without a result");

endmodule : array_list_engine_unit
`default_nettype wire
